@@ rtl/pvd_pkg.sv @@
package pvd_pkg;

    // Prefix byte codes for variable mode
    localparam logic [7:0] PREFIX_LIMIT = 8'd192;
    localparam logic [7:0] UPAY_LOW     = 8'd200;
    localparam logic [7:0] UPAY_HIGH    = 8'd207;
    localparam logic [7:0] SPAY_BIAS    = 8'd199;
    localparam logic [7:0] SLEN_BIAS    = 8'd191;
    localparam logic [7:0] SMIN_CODE    = 8'd208;

    localparam logic [63:0] SMIN_VALUE  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [2:0] RAW_LAST     = 3'd7;

    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_BAD         = 1'b1;

    // One decoded number leaving the core
    typedef struct packed {
        logic        valid;
        logic [63:0] number;
        logic        status;
    } t_result;

    // Core state seen by the top level
    typedef struct packed {
        logic raw_mode;
        logic busy;
    } t_core_status;

endpackage

@@ rtl/pvd_in_if.sv @@
interface pvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       want_signed;

    modport source (output valid, output data_byte, output want_signed, input ready);
    modport sink   (input valid, input data_byte, input want_signed, output ready);
endinterface

@@ rtl/pvd_out_if.sv @@
interface pvd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] number;
    logic        status;

    modport source (output valid, output number, output status, input ready);
    modport sink   (input valid, input number, input status, output ready);
endinterface

@@ rtl/pvd_cfg_if.sv @@
interface pvd_cfg_if;
    logic valid;
    logic ready;
    logic raw_mode;

    modport source (output valid, output raw_mode, input ready);
    modport sink   (input valid, input raw_mode, output ready);
endinterface

@@ rtl/pvd_core.sv @@
module pvd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_raw_mode,
    input  logic                  i_take,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_want_signed,
    output pvd_pkg::t_result      o_result,
    output pvd_pkg::t_core_status o_status
);
    import pvd_pkg::*;

    logic        r_raw_mode, n_raw_mode;
    logic [3:0]  r_bytes_left, n_bytes_left;
    logic [63:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic [2:0]  r_raw_idx, n_raw_idx;

    logic [63:0] raw_word;
    logic [63:0] pay_word;
    logic [7:0]  ulen;
    logic [7:0]  slen;
    t_result     res;

    // Raw mode: drop the byte into its lane
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            raw_word[k*8 +: 8] = (r_raw_idx == 3'(k)) ? i_data_byte : r_acc[k*8 +: 8];
        end
    end

    // Payload shift (big-endian) and prefix length decode
    assign pay_word = {r_acc[55:0], i_data_byte};
    assign ulen     = i_data_byte - SPAY_BIAS;
    assign slen     = i_data_byte - SLEN_BIAS;

    // Next state and result
    always_comb begin
        n_raw_mode   = r_raw_mode;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_raw_idx    = r_raw_idx;
        res          = '0;

        if (i_cfg_we) begin
            // mode write abandons any partial number
            n_raw_mode   = i_cfg_raw_mode;
            n_bytes_left = '0;
            n_acc        = '0;
            n_neg        = 1'b0;
            n_raw_idx    = '0;
        end else if (i_take) begin
            if (r_raw_mode) begin
                if (r_raw_idx == RAW_LAST) begin
                    res.valid  = 1'b1;
                    res.number = raw_word;
                    res.status = STATUS_OK;
                    n_acc      = '0;
                    n_raw_idx  = '0;
                end else begin
                    n_acc     = raw_word;
                    n_raw_idx = r_raw_idx + 3'd1;
                end
            end else if (r_bytes_left != 4'd0) begin
                n_acc        = pay_word;
                n_bytes_left = r_bytes_left - 4'd1;
                if (r_bytes_left == 4'd1) begin
                    res.valid  = 1'b1;
                    res.number = r_neg ? (64'd0 - pay_word) : pay_word;
                    res.status = STATUS_OK;
                    n_acc      = '0;
                    n_neg      = 1'b0;
                end
            end else if (i_data_byte < PREFIX_LIMIT) begin
                // literal value
                res.valid  = 1'b1;
                res.number = {56'd0, i_data_byte};
                res.status = STATUS_OK;
            end else if (i_data_byte >= UPAY_LOW && i_data_byte <= UPAY_HIGH) begin
                // payload follows; same length rule for both signednesses
                n_bytes_left = ulen[3:0];
                n_acc        = '0;
                n_neg        = i_want_signed;
            end else if (!i_want_signed) begin
                res.valid  = 1'b1;
                res.number = ALL_ONES;
                res.status = STATUS_BAD;
            end else if (i_data_byte < UPAY_LOW) begin
                // signed short-form payload prefix
                n_bytes_left = slen[3:0];
                n_acc        = '0;
                n_neg        = 1'b1;
            end else if (i_data_byte == SMIN_CODE) begin
                res.valid  = 1'b1;
                res.number = SMIN_VALUE;
                res.status = STATUS_OK;
            end else begin
                res.valid  = 1'b1;
                res.number = '0;
                res.status = STATUS_BAD;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode   <= 1'b0;
            r_bytes_left <= '0;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_raw_idx    <= '0;
        end else begin
            r_raw_mode   <= n_raw_mode;
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_neg        <= n_neg;
            r_raw_idx    <= n_raw_idx;
        end
    end

    assign o_result        = res;
    assign o_status.raw_mode = r_raw_mode;
    assign o_status.busy     = (r_bytes_left != 4'd0) || (r_raw_idx != 3'd0);

endmodule

@@ rtl/pvd_out_reg.sv @@
module pvd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pvd_pkg::t_result i_result,
    output logic             o_can_take,
    pvd_out_if.source        out_ch
);
    import pvd_pkg::*;

    logic        r_valid, n_valid;
    logic [63:0] r_number;
    logic        r_status;
    logic        load;

    // Slot is free when empty or drained this cycle
    assign o_can_take = !r_valid || out_ch.ready;
    assign load       = i_result.valid;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (out_ch.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_number <= i_result.number;
            r_status <= i_result.status;
        end
    end

    assign out_ch.valid  = r_valid;
    assign out_ch.number = r_number;
    assign out_ch.status = r_status;

endmodule

@@ rtl/prefixed_varint_byte_decoder.sv @@
// Channel  | Dir | Payload                      | Handshake
// ---------+-----+------------------------------+-------------------
// in_ch    | in  | data_byte[7:0], want_signed  | valid / ready
// cfg_ch   | in  | raw_mode                     | valid / ready (always ready)
// out_ch   | out | number[63:0], status         | valid / ready
//
// One byte per cycle while in_ch.ready is high: every byte finishes in the
// cycle it is accepted, and its number (if any) sits in the output register
// the next cycle. Throughput is set by the single output register: a new byte
// is taken when the register is empty or drained and no mode write waits.
// Synchronous reset (i_rst_n low) selects variable mode, clears control state.
// A stalled output holds in_ch.ready low until the waiting number is taken;
// a mode request holds in_ch.ready low for the cycle it is offered.
module prefixed_varint_byte_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pvd_in_if.sink    in_ch,
    pvd_cfg_if.sink   cfg_ch,
    pvd_out_if.source out_ch
);
    import pvd_pkg::*;

    logic         can_take;
    logic         take;
    logic         cfg_we;
    t_result      result;
    t_core_status core_stat;

    // Request handshakes; a mode write takes priority over a byte
    assign in_ch.ready  = can_take && !cfg_ch.valid;
    assign take         = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign cfg_we       = cfg_ch.valid;

    pvd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_raw_mode (cfg_ch.raw_mode),
        .i_take         (take),
        .i_data_byte    (in_ch.data_byte),
        .i_want_signed  (in_ch.want_signed),
        .o_result       (result),
        .o_status       (core_stat)
    );

    pvd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .o_can_take (can_take),
        .out_ch     (out_ch)
    );

`ifndef SYNTH
    // raw numbers never carry a bad status
    a_raw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid && core_stat.raw_mode |-> result.status == STATUS_OK)
        else $error("raw mode produced a bad status");

    // a bad prefix yields only all ones or zero
    a_bad_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid && result.status == STATUS_BAD |->
            (result.number == ALL_ONES || result.number == 64'd0))
        else $error("bad status with unexpected number");

    // input backpressure only comes from a waiting result or a mode write
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ch.ready |-> cfg_ch.valid || (out_ch.valid && !out_ch.ready))
        else $error("input stalled without a waiting result");

    // a produced result is visible on the port next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.valid |=> out_ch.valid)
        else $error("result lost before output register");
`endif

endmodule

@@ sim/prefixed_varint_byte_decoder_checker.sv @@
`timescale 1ns / 100ps

// Watches the byte, mode and number channels, predicts every decoded number
// from the accepted bytes and compares it with what leaves the block.
module prefixed_varint_byte_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pvd_in_if    in_ch,
    pvd_cfg_if   cfg_ch,
    pvd_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_bad_results
);
    import pvd_pkg::*;

    typedef struct packed {
        logic [63:0] number;
        logic        status;
    } t_decoded;

    // Numbers predicted but not yet seen on the output
    t_decoded expected_numbers[$];

    // Predictor copy of the decoder state
    logic        raw_mode;
    logic [3:0]  bytes_left;
    logic [63:0] accumulator;
    logic        negate_pending;
    logic [2:0]  raw_byte_index;

    task automatic clear_decoder();
        bytes_left     = '0;
        accumulator    = '0;
        negate_pending = 1'b0;
        raw_byte_index = '0;
    endtask

    task automatic push_number(input logic [63:0] value, input logic status);
        t_decoded item;
        item.number = value;
        item.status = status;
        expected_numbers.insert(expected_numbers.size(), item);
    endtask

    // Prefix announces a payload; length is the low nibble of the biased code
    task automatic start_payload(input logic [7:0] len, input logic negate);
        bytes_left     = len[3:0];
        accumulator    = '0;
        negate_pending = negate;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic sgn);
        logic [63:0] value;
        if (raw_mode) begin
            // Little-endian assembly, one number per eight bytes
            accumulator = accumulator | ({56'd0, b} << {raw_byte_index, 3'b000});
            if (raw_byte_index == RAW_LAST) begin
                push_number(accumulator, STATUS_OK);
                clear_decoder();
            end else begin
                raw_byte_index = raw_byte_index + 3'd1;
            end
        end else if (bytes_left != 4'd0) begin
            // Big-endian payload byte
            accumulator = {accumulator[55:0], b};
            bytes_left  = bytes_left - 4'd1;
            if (bytes_left == 4'd0) begin
                value = negate_pending ? (64'd0 - accumulator) : accumulator;
                push_number(value, STATUS_OK);
                clear_decoder();
            end
        end else if (b < PREFIX_LIMIT) begin
            push_number({56'd0, b}, STATUS_OK);
        end else if (!sgn) begin
            if (b < UPAY_LOW || b > UPAY_HIGH) begin
                push_number(ALL_ONES, STATUS_BAD);
            end else begin
                start_payload(b - SPAY_BIAS, 1'b0);
            end
        end else if (b >= UPAY_LOW && b <= UPAY_HIGH) begin
            start_payload(b - SPAY_BIAS, 1'b1);
        end else if (b < UPAY_LOW) begin
            start_payload(b - SLEN_BIAS, 1'b1);
        end else if (b == SMIN_CODE) begin
            push_number(SMIN_VALUE, STATUS_OK);
        end else begin
            push_number('0, STATUS_BAD);
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            raw_mode = 1'b0;
            clear_decoder();
            expected_numbers.delete();
            o_fail_count  = 0;
            o_results     = 0;
            o_bad_results = 0;
        end else begin
            // Compare the number taken this edge with the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (expected_numbers.size() == 0) begin
                    $error("unexpected result: number %h status %b",
                           out_ch.number, out_ch.status);
                    o_fail_count++;
                end else begin
                    want = expected_numbers.pop_front();
                    o_results++;
                    if (want.status == STATUS_BAD) o_bad_results++;
                    if (out_ch.number !== want.number) begin
                        $error("number mismatch: expected %h, got %h",
                               want.number, out_ch.number);
                        o_fail_count++;
                    end
                    if (out_ch.status !== want.status) begin
                        $error("status mismatch: expected %b, got %b",
                               want.status, out_ch.status);
                        o_fail_count++;
                    end
                end
            end
            // Mode write drops any partly received number
            if (cfg_ch.valid && cfg_ch.ready) begin
                raw_mode = cfg_ch.raw_mode;
                clear_decoder();
            end
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte, in_ch.want_signed);
            end
        end
        o_pending = expected_numbers.size();
    end

endmodule

@@ sim/prefixed_varint_byte_decoder_tb.sv @@
`timescale 1ns / 100ps

module prefixed_varint_byte_decoder_tb;

    import pvd_pkg::*;

    localparam logic MODE_VARIABLE   = 1'b0;
    localparam logic MODE_RAW        = 1'b1;
    localparam int   PHASES          = 6;
    localparam int   PHASE_BYTES     = 100;
    localparam int   HOLD_OFF_CYCLES = 60;
    localparam int   SETTLE_CYCLES   = 4;
    localparam int   TAIL_CYCLES     = 10;
    localparam int   STALL_LIMIT     = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pvd_in_if  in_ch ();
    pvd_cfg_if cfg_ch ();
    pvd_out_if out_ch ();

    int fail_count;
    int pending;
    int results;
    int bad_results;
    int bytes_sent  = 0;
    int mode_writes = 0;
    int idle_cycles = 0;
    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    prefixed_varint_byte_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    prefixed_varint_byte_decoder_checker number_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .cfg_ch        (cfg_ch),
        .out_ch        (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_bad_results (bad_results)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit roll_idle();
        return !no_idle && ($urandom_range(99) < 37);
    endfunction

    // Payload and raw bytes lean toward the extremes now and then
    function automatic logic [7:0] random_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic sgn);
        while (roll_idle()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.want_signed <= sgn;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.raw_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        mode_writes++;
    endtask

    // Stop offering bytes and wait until every predicted number is out
    task automatic settle(input int extra);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // One well-formed variable-mode number, or now and then a bad prefix
    task automatic send_variable_number();
        int         kind;
        logic       sgn;
        logic [7:0] prefix;
        int         len;
        kind = $urandom_range(99);
        sgn  = 1'($urandom_range(1));
        if (kind < 45) begin
            send_byte(8'($urandom_range(PREFIX_LIMIT - 1)), sgn);
        end else if (kind < 85) begin
            if (sgn) prefix = 8'($urandom_range(UPAY_HIGH, PREFIX_LIMIT));
            else     prefix = 8'($urandom_range(UPAY_HIGH, UPAY_LOW));
            len = (sgn && prefix < UPAY_LOW) ? int'(8'(prefix - SLEN_BIAS))
                                             : int'(8'(prefix - SPAY_BIAS));
            send_byte(prefix, sgn);
            repeat (len) send_byte(random_byte(), 1'($urandom_range(1)));
        end else if (kind < 90) begin
            send_byte(SMIN_CODE, 1'b1);
        end else if (sgn) begin
            send_byte(8'($urandom_range(8'hFF, SMIN_CODE + 1)), 1'b1);
        end else if ($urandom_range(1)) begin
            send_byte(8'($urandom_range(SPAY_BIAS, PREFIX_LIMIT)), 1'b0);
        end else begin
            send_byte(8'($urandom_range(8'hFF, SMIN_CODE)), 1'b0);
        end
    endtask

    // Output side: random back-pressure plus an occasional long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else begin
                out_ch.ready <= !roll_idle();
            end
        end
    end

    // Watchdog: too long without any request moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic mode;
        int   start;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.want_signed = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.raw_mode   = MODE_VARIABLE;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single-byte values and invalid prefixes
        send_byte(8'd0, 1'b0);
        send_byte(8'(PREFIX_LIMIT - 8'd1), 1'b1);
        send_byte(PREFIX_LIMIT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SMIN_CODE, 1'b1);
        send_byte(8'(SMIN_CODE + 8'd1), 1'b1);
        // shortest unsigned payload
        send_byte(UPAY_LOW, 1'b0);
        send_byte(8'hAB, 1'b0);
        // negated zero stays zero
        send_byte(PREFIX_LIMIT, 1'b1);
        send_byte(8'h00, 1'b1);
        // longest signed payload, negated
        send_byte(SPAY_BIAS, 1'b1);
        send_byte(8'h80, 1'b0);
        repeat (6) send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        // partial number dropped by the mode write
        send_byte(8'(UPAY_LOW + 8'd3), 1'b0);
        send_byte(8'h5A, 1'b0);
        settle(SETTLE_CYCLES);
        write_mode(MODE_RAW);

        // Directed raw: one full number, then a partial one left behind
        for (int i = 0; i < 8; i++) send_byte(8'(8'h01 + 8'h22 * i), 1'(i));
        repeat (3) send_byte(8'hFF, 1'b1);

        // Random phases alternating between the two modes
        for (int p = 0; p < PHASES; p++) begin
            mode = (p % 2 == 0) ? MODE_VARIABLE : MODE_RAW;
            settle(SETTLE_CYCLES);
            write_mode(mode);
            no_idle = (p == 2);
            if (p == 1 || p == 4) hold_off_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if (mode == MODE_RAW) send_byte(random_byte(), 1'($urandom_range(1)));
                else                  send_variable_number();
            end
        end
        no_idle = 1'b0;
        settle(TAIL_CYCLES);

        $display("Sent %0d bytes over %0d mode writes, raw and variable, both signednesses,",
                 bytes_sent, mode_writes);
        $display("with a %0d-cycle output hold-off; %0d numbers checked, %0d invalid.",
                 HOLD_OFF_CYCLES, results, bad_results);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
